[src/hcb_pkg.sv]
// Package: shared constants, state encoding and controller/datapath command and status types.
`timescale 1ns / 1ps
`default_nettype none
package hcb_pkg;
  localparam int MAX_LEAVES_DEF = 16;
  localparam int SYM_W  = 8;
  localparam int LW_W   = 10;
  localparam int CODE_W = 15;
  localparam int CLEN_W = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MERGE,
    ST_SCAN,
    ST_WR_A,
    ST_WR_B,
    ST_WR_P,
    ST_WALK_INIT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_WALK_LFT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan;
    logic wr_a;
    logic wr_b;
    logic wr_p;
    logic walk_init;
    logic walk_rd;
    logic walk_chk;
    logic walk_step;
    logic next_leaf;
  } dp_cmd_t;

  typedef struct packed {
    logic merge_done;
    logic scan_done;
    logic has_parent;
    logic last_leaf;
  } dp_status_t;
endpackage
`default_nettype wire

[src/hcb_datapath.sv]
// Datapath: node memories, merge scan, leaf-to-root walk and result registers.
`timescale 1ns / 1ps
`default_nettype none
module hcb_datapath #(
  parameter int MAX_LEAVES = hcb_pkg::MAX_LEAVES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire hcb_pkg::dp_cmd_t          cmd,
  output hcb_pkg::dp_status_t            status,
  input  wire logic [hcb_pkg::SYM_W-1:0] symbol,
  input  wire logic [hcb_pkg::LW_W-1:0]  weight,
  input  wire logic                      last,
  output logic [hcb_pkg::SYM_W-1:0]      leaf_symbol,
  output logic [hcb_pkg::CODE_W-1:0]     code_bits,
  output logic [hcb_pkg::CLEN_W-1:0]     code_length
);
  localparam int NODES = 2 * MAX_LEAVES;
  localparam int NW    = $clog2(NODES);
  localparam int LCW   = $clog2(MAX_LEAVES + 1);
  localparam int LIW   = $clog2(MAX_LEAVES);
  localparam int LIMIT = MAX_LEAVES * 1023 + 1;
  localparam int WW    = $clog2(LIMIT + 1);
  localparam int LENW  = (LIW > hcb_pkg::CLEN_W) ? LIW : hcb_pkg::CLEN_W;

  logic [WW:0]   wmem [NODES];
  logic [NW-1:0] pmem [NODES];
  logic [NW-1:0] lmem [NODES];
  logic [hcb_pkg::SYM_W-1:0] smem [MAX_LEAVES];

  logic [LCW-1:0]  cnt, n;
  logic [NW-1:0]   p, idx, didx, a, b, k;
  logic            dv;
  logic [WW-1:0]   m1, m2;
  logic [WW:0]     wq;
  logic [NW-1:0]   pq, lq;
  logic [LIW-1:0]  li;
  logic [LENW-1:0] len;
  logic [hcb_pkg::CODE_W-1:0] code;
  logic [hcb_pkg::SYM_W-1:0]  sym_q;
  logic [LCW-1:0]  cnt_next;

  logic          w_en;
  logic [NW-1:0] w_addr;
  logic [WW:0]   w_data;
  logic          r_en;
  logic [NW-1:0] r_addr;

  assign cnt_next = (cnt < LCW'(MAX_LEAVES)) ? cnt + 1'b1 : cnt;

  always_comb begin
    w_en   = 1'b0;
    w_addr = a;
    w_data = {1'b1, m1};
    if (cmd.load && (cnt < LCW'(MAX_LEAVES))) begin
      w_en   = 1'b1;
      w_addr = NW'(cnt);
      w_data = {1'b0, WW'(weight)};
    end else if (cmd.wr_a) begin
      w_en = 1'b1;
    end else if (cmd.wr_b) begin
      w_en   = 1'b1;
      w_addr = b;
      w_data = {1'b1, m2};
    end else if (cmd.wr_p) begin
      w_en   = 1'b1;
      w_addr = p;
      w_data = {1'b0, m1 + m2};
    end
    r_en   = (cmd.scan && (idx < p)) || cmd.walk_rd;
    r_addr = cmd.scan ? idx : k;
  end

  always_ff @(posedge clk) begin
    if (w_en) begin
      wmem[w_addr] <= w_data;
    end
    if (cmd.wr_a) begin
      pmem[a] <= p;
    end
    if (cmd.wr_b) begin
      pmem[b] <= p;
    end
    if (cmd.wr_p) begin
      lmem[p] <= a;
    end
    if (cmd.load && (cnt < LCW'(MAX_LEAVES))) begin
      smem[cnt[LIW-1:0]] <= symbol;
    end
    if (r_en) begin
      wq <= wmem[r_addr];
      pq <= pmem[r_addr];
    end
    if (cmd.walk_chk) begin
      lq <= lmem[pq];
    end
    if (cmd.walk_init) begin
      sym_q <= smem[li];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      dv  <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= last ? '0 : cnt_next;
        if (last) begin
          n  <= cnt_next;
          p  <= NW'(cnt_next);
          li <= '0;
        end
      end
      if (cmd.scan_clr) begin
        idx <= '0;
        dv  <= 1'b0;
        m1  <= WW'(LIMIT);
        m2  <= WW'(LIMIT);
        a   <= '0;
        b   <= '0;
      end
      if (cmd.scan) begin
        dv   <= idx < p;
        didx <= idx;
        if (idx < p) begin
          idx <= idx + 1'b1;
        end
        if (dv && !wq[WW]) begin
          if (wq[WW-1:0] < m1) begin
            m2 <= m1;
            b  <= a;
            m1 <= wq[WW-1:0];
            a  <= didx;
          end else if (wq[WW-1:0] < m2) begin
            m2 <= wq[WW-1:0];
            b  <= didx;
          end
        end
      end
      if (cmd.wr_p) begin
        p <= p + 1'b1;
      end
      if (cmd.walk_init) begin
        k    <= NW'(li);
        len  <= '0;
        code <= '0;
      end
      if (cmd.walk_step) begin
        if ((lq != k) && (len < LENW'(hcb_pkg::CODE_W))) begin
          code[len[hcb_pkg::CLEN_W-1:0]] <= 1'b1;
        end
        len <= len + 1'b1;
        k   <= pq;
      end
      if (cmd.next_leaf) begin
        li <= li + 1'b1;
      end
    end
  end

  assign status.merge_done = (({1'b0, p} + 1'b1) == ((NW + 1)'(n) << 1));
  assign status.scan_done  = (idx == p) && !dv;
  assign status.has_parent = wq[WW];
  assign status.last_leaf  = ((LCW'(li) + 1'b1) == n);

  assign leaf_symbol = sym_q;
  assign code_bits   = code;
  assign code_length = len[hcb_pkg::CLEN_W-1:0];
endmodule
`default_nettype wire

[src/hcb_ctrl.sv]
// Controller: sequences load, merges, code walks and result beats.
`timescale 1ns / 1ps
`default_nettype none
module hcb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                last,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hcb_pkg::dp_cmd_t         cmd,
  input  wire hcb_pkg::dp_status_t status
);
  hcb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      hcb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (last) begin
            state_next = hcb_pkg::ST_MERGE;
          end
        end
      end
      hcb_pkg::ST_MERGE: begin
        if (status.merge_done) begin
          state_next = hcb_pkg::ST_WALK_INIT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = hcb_pkg::ST_SCAN;
        end
      end
      hcb_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = hcb_pkg::ST_WR_A;
        end
      end
      hcb_pkg::ST_WR_A: begin
        cmd.wr_a   = 1'b1;
        state_next = hcb_pkg::ST_WR_B;
      end
      hcb_pkg::ST_WR_B: begin
        cmd.wr_b   = 1'b1;
        state_next = hcb_pkg::ST_WR_P;
      end
      hcb_pkg::ST_WR_P: begin
        cmd.wr_p   = 1'b1;
        state_next = hcb_pkg::ST_MERGE;
      end
      hcb_pkg::ST_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        state_next    = hcb_pkg::ST_WALK_RD;
      end
      hcb_pkg::ST_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = hcb_pkg::ST_WALK_CHK;
      end
      hcb_pkg::ST_WALK_CHK: begin
        if (status.has_parent) begin
          cmd.walk_chk = 1'b1;
          state_next   = hcb_pkg::ST_WALK_LFT;
        end else begin
          state_next = hcb_pkg::ST_EMIT;
        end
      end
      hcb_pkg::ST_WALK_LFT: begin
        cmd.walk_step = 1'b1;
        state_next    = hcb_pkg::ST_WALK_RD;
      end
      hcb_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last_leaf) begin
            state_next = hcb_pkg::ST_IDLE;
          end else begin
            cmd.next_leaf = 1'b1;
            state_next    = hcb_pkg::ST_WALK_INIT;
          end
        end
      end
      default: state_next = hcb_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[src/huffman_code_builder_top.sv]
// Top level: Huffman code builder, controller plus datapath.
// Leaves load one beat per cycle while idle; leaves past MAX_LEAVES are dropped.
// A beat with last set starts the build and blocks input until every code beat
// is taken. For n leaves the build makes n-1 merges; merge number i scans the
// n+i existing nodes through the node weight memory, one per cycle. Each code
// is then found by walking from its leaf up to the root, one tree level at a
// time, and a result beat waits in the output register until taken.
`timescale 1ns / 1ps
`default_nettype none
module huffman_code_builder_top #(
  parameter int MAX_LEAVES = hcb_pkg::MAX_LEAVES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [hcb_pkg::SYM_W-1:0]  symbol,
  input  wire logic [hcb_pkg::LW_W-1:0]   weight,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hcb_pkg::SYM_W-1:0]       leaf_symbol,
  output logic [hcb_pkg::CODE_W-1:0]      code_bits,
  output logic [hcb_pkg::CLEN_W-1:0]      code_length,
  output logic                            final_res
);
  hcb_pkg::dp_cmd_t    cmd;
  hcb_pkg::dp_status_t status;

  hcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  hcb_datapath #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .symbol      (symbol),
    .weight      (weight),
    .last        (last),
    .leaf_symbol (leaf_symbol),
    .code_bits   (code_bits),
    .code_length (code_length)
  );

  assign final_res = status.last_leaf;
endmodule
`default_nettype wire

[tb/sv/huffman_code_builder_checker.sv]
// Checker: predicts Huffman codes from the accepted leaf beats and compares code beats.
`timescale 1ns / 1ps
`default_nettype none
module huffman_code_builder_checker #(
  parameter int MAX_LEAVES = hcb_pkg::MAX_LEAVES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic [hcb_pkg::SYM_W-1:0] symbol,
  input  wire logic [hcb_pkg::LW_W-1:0]  weight,
  input  wire logic                      last,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic [hcb_pkg::SYM_W-1:0] leaf_symbol,
  input  wire logic [hcb_pkg::CODE_W-1:0] code_bits,
  input  wire logic [hcb_pkg::CLEN_W-1:0] code_length,
  input  wire logic                      final_res,
  output int                             fail_count,
  output int                             pending_codes,
  output int                             codes_seen,
  output int                             builds_seen
);
  localparam int SYM_W  = hcb_pkg::SYM_W;
  localparam int CODE_W = hcb_pkg::CODE_W;
  localparam int CLEN_W = hcb_pkg::CLEN_W;
  localparam int NODES = 2 * MAX_LEAVES;
  localparam int WLIM = MAX_LEAVES * 1023 + 1;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] bits;
    logic [CLEN_W-1:0] len;
    logic              fin;
  } code_beat_t;

  code_beat_t expected_codes[$];
  int unsigned tree_weight[NODES];
  int unsigned tree_parent[NODES];
  bit          tree_linked[NODES];
  int unsigned tree_left[NODES];
  logic [SYM_W-1:0] held_symbols[MAX_LEAVES];
  int unsigned held_count;

  task automatic build_codes();
    int unsigned n, a, b, p, m1, m2, k, f, depth;
    logic [63:0] path;
    code_beat_t cb;
    n = held_count;
    for (int i = 0; i + 1 < n; i++) begin
      p = n + i;
      m1 = WLIM; m2 = WLIM; a = 0; b = 0;
      for (int j = 0; j < p; j++) begin
        if (tree_linked[j]) continue;
        if (tree_weight[j] < m1) begin
          m2 = m1; b = a; m1 = tree_weight[j]; a = j;
        end else if (tree_weight[j] < m2) begin
          m2 = tree_weight[j]; b = j;
        end
      end
      tree_parent[a] = p; tree_linked[a] = 1;
      tree_parent[b] = p; tree_linked[b] = 1;
      tree_left[p] = a;
      tree_weight[p] = tree_weight[a] + tree_weight[b];
      tree_linked[p] = 0;
    end
    for (int i = 0; i < n; i++) begin
      path = '0; depth = 0; k = i;
      while (tree_linked[k] && depth < 63) begin
        f = tree_parent[k];
        if (tree_left[f] != k) path[depth] = 1'b1;
        depth++;
        k = f;
      end
      cb.sym = held_symbols[i];
      cb.bits = path[CODE_W-1:0];
      cb.len = depth[CLEN_W-1:0];
      cb.fin = (i + 1 == n);
      expected_codes.push_back(cb);
    end
    held_count = 0;
  endtask

  always @(posedge clk) begin
    code_beat_t exp_cb;
    if (rst) begin
      held_count = 0;
      expected_codes.delete();
      fail_count = 0;
      codes_seen = 0;
      builds_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected code beat sym=%0h bits=%0h len=%0d fin=%0b",
                   $time, leaf_symbol, code_bits, code_length, final_res);
        end else begin
          exp_cb = expected_codes.pop_front();
          if (leaf_symbol !== exp_cb.sym || code_bits !== exp_cb.bits ||
              code_length !== exp_cb.len || final_res !== exp_cb.fin) begin
            fail_count++;
            $display("%0t: mismatch expected sym=%0h bits=%0h len=%0d fin=%0b",
                     $time, exp_cb.sym, exp_cb.bits, exp_cb.len, exp_cb.fin);
            $display("%0t:          actual   sym=%0h bits=%0h len=%0d fin=%0b",
                     $time, leaf_symbol, code_bits, code_length, final_res);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (held_count < MAX_LEAVES) begin
          held_symbols[held_count] = symbol;
          tree_weight[held_count] = weight;
          tree_linked[held_count] = 0;
          tree_left[held_count] = 0;
          held_count++;
        end
        if (last) begin
          builds_seen++;
          build_codes();
        end
      end
    end
    pending_codes = expected_codes.size();
  end
endmodule
`default_nettype wire

[tb/sv/huffman_code_builder_top_tb.sv]
// Testbench top: drives leaf sets into the code builder and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module huffman_code_builder_top_tb;
  localparam int SYM_W  = hcb_pkg::SYM_W;
  localparam int LW_W   = hcb_pkg::LW_W;
  localparam int CODE_W = hcb_pkg::CODE_W;
  localparam int CLEN_W = hcb_pkg::CLEN_W;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, last = 0;
  logic [SYM_W-1:0] symbol = '0;
  logic [LW_W-1:0] weight = '0;
  logic out_valid, out_ready = 0, final_res;
  logic [SYM_W-1:0] leaf_symbol;
  logic [CODE_W-1:0] code_bits;
  logic [CLEN_W-1:0] code_length;
  int fail_count, pending_codes, codes_seen, builds_seen;
  int leaves_sent = 0;
  int burst_left = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  huffman_code_builder_top i_dut (
    .clk, .rst, .in_valid, .in_ready, .symbol, .weight, .last,
    .out_valid, .out_ready, .leaf_symbol, .code_bits, .code_length, .final_res
  );

  huffman_code_builder_checker i_chk (
    .clk, .rst, .in_valid, .in_ready, .symbol, .weight, .last,
    .out_valid, .out_ready, .leaf_symbol, .code_bits, .code_length, .final_res,
    .fail_count, .pending_codes, .codes_seen, .builds_seen
  );

  // stall pattern: calm, heavy and none in turn
  always @(negedge clk) begin
    int phase;
    phase = int'(($time / 4000) % 3);
    if (rst) out_ready <= 0;
    else if (phase == 2) out_ready <= 1;
    else if (phase == 1) out_ready <= ($urandom_range(0, 3) == 0);
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_leaf(input logic [SYM_W-1:0] s, input logic [LW_W-1:0] w,
                           input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1; symbol <= s; weight <= w; last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    leaves_sent++;
    @(negedge clk);
  endtask

  task automatic send_set(input int n, input int mode);
    logic [LW_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = LW_W'($urandom_range(0, 1023));
        1: w = LW_W'($urandom_range(0, 3));
        2: w = (i < 10) ? (LW_W'(1) << i) : LW_W'(1023);
        default: w = 0;
      endcase
      send_leaf(SYM_W'($urandom_range(0, 255)), w, i == n - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_codes != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_leaf(8'hFF, 10'h3FF, 1);
    send_leaf(8'h00, 10'h000, 0);
    send_leaf(8'hA5, 10'h000, 1);
    send_set(16, 3);
    drain();
    send_set(16, 2);
    send_set(20, 1);
    send_leaf(8'h5A, 10'h155, 0);
    send_leaf(8'h3C, 10'h2AA, 1);
    drain();
    repeat (20) @(negedge clk);
    while (leaves_sent < 160) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 16);
      send_set(n, $urandom_range(0, 2));
    end
    drain();
    repeat (50) @(negedge clk);
    $display("covered %0d leaf beats, %0d builds, %0d code beats",
             leaves_sent, builds_seen, codes_seen);
    if (fail_count == 0 && pending_codes == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
src/hcb_pkg.sv
src/hcb_datapath.sv
src/hcb_ctrl.sv
src/huffman_code_builder_top.sv
tb/sv/huffman_code_builder_checker.sv
tb/sv/huffman_code_builder_top_tb.sv
